// ===== design/swm_pkg.sv =====
// Package for the streaming wildcard matcher: shared sizes, the configuration
// register index codes and the structs that pass between the modules.
// No dependencies.
package swm_pkg;

    localparam int MAX_ATOMS = 16;
    localparam int POS_W     = MAX_ATOMS + 1;
    localparam int CNT_W     = 5;
    localparam int CHARS_W   = 8 * MAX_ATOMS;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHARS_LO  = 3'd0,
        CFG_CHARS_HI  = 3'd1,
        CFG_ANY_MASK  = 3'd2,
        CFG_NSP_MASK  = 3'd3,
        CFG_REP_MASK  = 3'd4,
        CFG_NUM_ATOMS = 3'd5,
        CFG_FOLD_CASE = 3'd6
    } t_cfg_idx;

    // Pattern as held in the configuration registers.
    typedef struct packed {
        logic [CHARS_W-1:0]   chars;
        logic [MAX_ATOMS-1:0] any_mask;
        logic [MAX_ATOMS-1:0] nsp_mask;
        logic [MAX_ATOMS-1:0] rep_mask;
        logic [CNT_W-1:0]     num_atoms;
        logic                 fold_case;
    } t_cfg;

    // Next match state produced for one byte.
    typedef struct packed {
        logic [POS_W-1:0] positions;
        logic             found;
    } t_step_res;

endpackage

// ===== design/streaming_wildcard_matcher_top.sv =====
// Streaming wildcard matcher, top level. A byte beat is held in an input
// register, stepped through the pattern automaton and its found
// flag is held in a result register. Uses swm_pkg, swm_cfg_regs and swm_step.
//
// The block searches a byte stream, one byte per beat, for a pattern of up
// to sixteen atoms kept in configuration registers; each atom is a literal
// byte, any byte or any non-space byte, and may repeat zero or more times.
// Every input beat gives exactly one result beat carrying the sticky found
// flag. The block takes one beat per cycle when the result side does not
// stall; a byte waits in the input register and, as it moves on, its flag is
// loaded into the result register, which presents the result beat. The whole
// position-vector update, two prefix closures around the atom compare, sits
// between these two registers and feeds its own state back, which sets that
// rate. The input side keeps taking beats while a result waits, as long as the
// input register is free or moving. After a match, bytes are ignored until a
// beat with restart set; restart with an empty pattern reports found at once.
// Configuration writes are always ready and must be made only while no beat
// is in flight.
module streaming_wildcard_matcher_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [swm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [swm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Text byte channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_restart,
    // Result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_found
);
    import swm_pkg::*;

    t_cfg             cfg;
    t_step_res        res;

    logic             r_in_valid;
    logic [7:0]       r_in_data;
    logic             r_in_restart;
    logic             r_out_valid;
    logic             r_found;
    logic [POS_W-1:0] r_positions;
    logic             r_match;

    logic             in_accept;
    logic             advance;

    swm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    swm_step u_step (
        .i_cfg       (cfg),
        .i_positions (r_positions),
        .i_match     (r_match),
        .i_data_byte (r_in_data),
        .i_restart   (r_in_restart),
        .o_res       (res)
    );

    // The held byte moves on when the result register is empty or is being
    // drained in this cycle; the automaton state advances at the same edge.
    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_positions <= '0;
            r_match     <= 1'b1;
        end else begin
            r_in_valid <= in_accept || (r_in_valid && !advance);
            if (advance) begin
                r_out_valid <= 1'b1;
                r_positions <= res.positions;
                r_match     <= res.found;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_data    <= i_data_byte;
            r_in_restart <= i_restart;
        end
        if (advance) begin
            r_found <= res.found;
        end
    end

endmodule

// ===== design/swm_cfg_regs.sv =====
// Configuration register file of the streaming wildcard matcher.
// Depends on swm_pkg for the index codes and the pattern struct.
module swm_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [swm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [swm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output swm_pkg::t_cfg                  o_cfg
);
    import swm_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CHARS_LO:  r_cfg.chars[CFG_DATA_W-1:0] <= i_cfg_data;
                CFG_CHARS_HI:  r_cfg.chars[CHARS_W-1:CFG_DATA_W] <= i_cfg_data;
                CFG_ANY_MASK:  r_cfg.any_mask <= i_cfg_data[MAX_ATOMS-1:0];
                CFG_NSP_MASK:  r_cfg.nsp_mask <= i_cfg_data[MAX_ATOMS-1:0];
                CFG_REP_MASK:  r_cfg.rep_mask <= i_cfg_data[MAX_ATOMS-1:0];
                CFG_NUM_ATOMS: r_cfg.num_atoms <= i_cfg_data[CNT_W-1:0];
                CFG_FOLD_CASE: r_cfg.fold_case <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

// ===== design/swm_step.sv =====
// Next-state logic of the matcher for one text byte: atom compare, the two
// repeat-skip closures (parallel prefix) and the sticky flag. Uses swm_pkg.
module swm_step (
    input  swm_pkg::t_cfg               i_cfg,
    input  logic [swm_pkg::POS_W-1:0]   i_positions,
    input  logic                        i_match,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_restart,
    output swm_pkg::t_step_res          o_res
);
    import swm_pkg::*;

    localparam int LEVELS = $clog2(POS_W);
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;

    // A set bit j carries into j+1 when atom j repeats. Written as a
    // carry-lookahead: pp[j] says bit j-1 passes through into bit j.
    function automatic logic [POS_W-1:0] closure(input logic [POS_W-1:0] s,
                                                 input logic [POS_W-1:0] pp);
        logic [POS_W-1:0] g;
        logic [POS_W-1:0] p;
        logic [POS_W-1:0] g_nx;
        logic [POS_W-1:0] p_nx;
        g = s;
        p = pp;
        for (int lv = 0; lv < LEVELS; lv++) begin
            for (int j = 0; j < POS_W; j++) begin
                if (j >= (1 << lv)) begin
                    g_nx[j] = g[j] | (p[j] & g[j - (1 << lv)]);
                    p_nx[j] = p[j] & p[j - (1 << lv)];
                end else begin
                    g_nx[j] = g[j];
                    p_nx[j] = 1'b0;
                end
            end
            g = g_nx;
            p = p_nx;
        end
        return g;
    endfunction

    function automatic logic [7:0] fold(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) ? b - 8'h20 : b;
    endfunction

    logic [CNT_W-1:0]     n_used;
    logic [POS_W-1:0]     live;
    logic [POS_W-1:0]     pass;
    logic [MAX_ATOMS-1:0] hit;
    logic [MAX_ATOMS-1:0] step_on;
    logic [POS_W-1:0]     cur;
    logic [POS_W-1:0]     nxt;
    logic [POS_W-1:0]     nxt_closed;
    logic [POS_W-1:0]     pos_eff;
    logic                 match_eff;
    logic                 is_space;
    logic [7:0]           lit;

    always_comb begin
        n_used = (i_cfg.num_atoms > CNT_W'(MAX_ATOMS)) ? CNT_W'(MAX_ATOMS)
                                                        : i_cfg.num_atoms;
        is_space = (i_data_byte == CH_NUL) || (i_data_byte == CH_TAB) ||
                   (i_data_byte == CH_LF)  || (i_data_byte == CH_CR)  ||
                   (i_data_byte == CH_SP);
        pass = '0;
        for (int j = 0; j < POS_W; j++) begin
            live[j] = (CNT_W'(j) <= n_used);
        end
        for (int i = 0; i < MAX_ATOMS; i++) begin
            pass[i + 1] = i_cfg.rep_mask[i] && (CNT_W'(i) < n_used);
            lit = i_cfg.chars[8*i +: 8];
            if (i_cfg.any_mask[i]) begin
                hit[i] = 1'b1;
            end else if (i_cfg.nsp_mask[i]) begin
                hit[i] = !is_space;
            end else if (i_cfg.fold_case) begin
                hit[i] = (fold(i_data_byte) == fold(lit));
            end else begin
                hit[i] = (i_data_byte == lit);
            end
        end

        // Restart clears positions and reloads the flag before the byte.
        pos_eff   = i_restart ? '0 : i_positions;
        match_eff = i_restart ? (n_used == '0) : i_match;

        cur = closure((pos_eff & live) | POS_W'(1), pass);
        for (int i = 0; i < MAX_ATOMS; i++) begin
            step_on[i] = cur[i] && hit[i] && (CNT_W'(i) < n_used);
        end
        // A repeating atom stays in place, any other moves on by one.
        nxt = {1'b0, step_on & i_cfg.rep_mask} | {step_on & ~i_cfg.rep_mask, 1'b0};
        nxt_closed = closure(nxt, pass);

        if (match_eff) begin
            o_res.positions = pos_eff;
            o_res.found     = 1'b1;
        end else begin
            o_res.positions = nxt_closed;
            o_res.found     = nxt_closed[n_used];
        end
    end

endmodule
